// ----- hw/rtl/wrv_pkg.sv -----
// Shared widths, register indexes, reset values and item kinds for the weighted running variance block.
package wrv_pkg;

    localparam int VALUE_W  = 32;
    localparam int WEIGHT_W = 16;
    localparam int COUNT_W  = 32;
    localparam int WSUM_W   = 48;
    localparam int MEAN_W   = 48;
    localparam int SQ_W     = 64;
    localparam int ROOT_W   = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MEAN_EST = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Z_VALUE  = 1'd1;

    // Configuration reset values
    localparam logic        MEAN_EST_RST = 1'b1;
    localparam logic [15:0] Z_VALUE_RST  = 16'd8028;

    // Input item kinds
    localparam logic KIND_PUSH  = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

endpackage

// ----- hw/rtl/weighted_running_variance.sv -----
// Weighted running variance: weighted Welford update with a sequencer over bit-serial units.
// A push that leaves the total weight above one, with the mean estimated, has the sequencer run
// the bit-serial multiplier (up to three uses), the restoring divider (up to three uses) and the
// square-root unit (up to two uses) back to back, one at a time. The block takes one request at
// a time and raises in_stall until the result has been placed in the output register; a finished
// result may wait there while the next request is worked.
module weighted_running_variance
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic signed [31:0]              sample_value,
    input  logic [15:0]                     sample_weight,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [31:0]                     unique_count,
    output logic [47:0]                     total_weight,
    output logic signed [47:0]              mean_out,
    output logic [63:0]                     variance_out,
    output logic [31:0]                     stdev_out,
    output logic [31:0]                     std_error,
    output logic [31:0]                     margin_error,
    output logic                            sem_undefined,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [wrv_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wrv_pkg::CFG_DATA_W-1:0]  cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPDATE,
        S_MUL1,
        S_DIV1,
        S_ESTART,
        S_MUL2,
        S_VAR,
        S_DIV2,
        S_SQ1,
        S_DIV3,
        S_SQ2,
        S_MUL3,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    // Configuration
    logic        mean_est_reg;
    logic [15:0] z_reg;

    // Latched request
    logic        kind_reg;
    logic [47:0] value_reg;
    logic [15:0] weight_reg;

    // Statistics state
    logic [31:0] count_reg, count_next;
    logic [47:0] wsum_reg, wsum_next;
    logic [47:0] mean_reg, mean_next;
    logic [63:0] sq_reg, sq_next;

    // Working values
    logic        dneg_reg, dneg_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] var_reg, var_next;
    logic [31:0] sd_reg, sd_next;
    logic [31:0] se_reg, se_next;
    logic [31:0] moe_reg, moe_next;

    // Output register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] o_count_reg;
    logic [47:0] o_wsum_reg;
    logic [47:0] o_mean_reg;
    logic [63:0] o_var_reg;
    logic [31:0] o_sd_reg;
    logic [31:0] o_se_reg;
    logic [31:0] o_moe_reg;
    logic        o_sem_reg;
    logic        out_load;

    // Unit handshakes
    logic         div_start, sqrt_start, mul_start;
    logic [63:0]  div_a;
    logic [47:0]  div_b;
    logic [63:0]  sqrt_x;
    logic [63:0]  mul_a, mul_b;
    logic         div_done, sqrt_done, mul_done;
    logic [63:0]  div_q;
    logic [31:0]  sqrt_r;
    logic [127:0] mul_p;

    // Datapath helpers
    logic [48:0] wsum_add;
    logic [48:0] diff;
    logic [48:0] dmag;
    logic [48:0] mean_step;
    logic [63:0] term;
    logic [64:0] sq_add;
    logic        in_take;

    wrv_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    wrv_sqrt u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sqrt_x),
        .done     (sqrt_done),
        .root     (sqrt_r)
    );

    wrv_mul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // Weight sum, difference from the mean and its magnitude, mean step and sum of squares
    assign wsum_add  = {1'b0, wsum_reg} + {33'd0, weight_reg};
    assign diff      = {value_reg[47], value_reg} - {mean_reg[47], mean_reg};
    assign dmag      = diff[48] ? (49'd0 - diff) : diff;
    assign mean_step = dneg_reg ? ({mean_reg[47], mean_reg} - div_q[48:0])
                                : ({mean_reg[47], mean_reg} + div_q[48:0]);
    assign term      = (mul_p[127:104] != 24'd0) ? {64{1'b1}} : mul_p[103:40];
    assign sq_add    = {1'b0, sq_reg} + {1'b0, term};

    // Sequence the shared units
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        wsum_next  = wsum_reg;
        mean_next  = mean_reg;
        sq_next    = sq_reg;
        dneg_next  = dneg_reg;
        prod_next  = prod_reg;
        var_next   = var_reg;
        sd_next    = sd_reg;
        se_next    = se_reg;
        moe_next   = moe_reg;
        out_load   = 1'b0;
        div_start  = 1'b0;
        sqrt_start = 1'b0;
        mul_start  = 1'b0;
        div_a      = '0;
        div_b      = '0;
        sqrt_x     = '0;
        mul_a      = '0;
        mul_b      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (kind_reg == wrv_pkg::KIND_CLEAR)
                begin
                    count_next = '0;
                    wsum_next  = '0;
                    mean_next  = '0;
                    sq_next    = '0;
                    state_next = S_VAR;
                end
                else
                begin
                    if (count_reg != {32{1'b1}})
                    begin
                        count_next = count_reg + 32'd1;
                    end
                    wsum_next = wsum_add[48] ? {48{1'b1}} : wsum_add[47:0];
                    if (weight_reg == 16'd0)
                    begin
                        state_next = S_VAR;
                    end
                    else
                    begin
                        dneg_next  = diff[48];
                        mul_start  = 1'b1;
                        mul_a      = {15'd0, dmag};
                        mul_b      = {48'd0, weight_reg};
                        state_next = S_MUL1;
                    end
                end
            end
            S_MUL1:
            begin
                if (mul_done)
                begin
                    prod_next  = mul_p[63:0];
                    div_start  = 1'b1;
                    div_a      = mul_p[63:0];
                    div_b      = wsum_reg;
                    state_next = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (div_done)
                begin
                    mean_next  = mean_step[47:0];
                    state_next = S_ESTART;
                end
            end
            S_ESTART:
            begin
                mul_start  = 1'b1;
                mul_a      = prod_reg;
                mul_b      = {15'd0, dmag};
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                if (mul_done)
                begin
                    sq_next    = sq_add[64] ? {64{1'b1}} : sq_add[63:0];
                    state_next = S_VAR;
                end
            end
            S_VAR:
            begin
                if (wsum_reg > 48'd1)
                begin
                    div_start  = 1'b1;
                    div_a      = sq_reg;
                    div_b      = mean_est_reg ? (wsum_reg - 48'd1) : wsum_reg;
                    state_next = S_DIV2;
                end
                else
                begin
                    var_next   = '0;
                    sd_next    = '0;
                    se_next    = '0;
                    moe_next   = '0;
                    state_next = S_DONE;
                end
            end
            S_DIV2:
            begin
                if (div_done)
                begin
                    var_next   = div_q;
                    sqrt_start = 1'b1;
                    sqrt_x     = div_q;
                    state_next = S_SQ1;
                end
            end
            S_SQ1:
            begin
                if (sqrt_done)
                begin
                    sd_next = sqrt_r;
                    if (mean_est_reg)
                    begin
                        div_start  = 1'b1;
                        div_a      = var_reg;
                        div_b      = wsum_reg;
                        state_next = S_DIV3;
                    end
                    else
                    begin
                        se_next    = '0;
                        moe_next   = '0;
                        state_next = S_DONE;
                    end
                end
            end
            S_DIV3:
            begin
                if (div_done)
                begin
                    sqrt_start = 1'b1;
                    sqrt_x     = div_q;
                    state_next = S_SQ2;
                end
            end
            S_SQ2:
            begin
                if (sqrt_done)
                begin
                    se_next    = sqrt_r;
                    mul_start  = 1'b1;
                    mul_a      = {48'd0, z_reg};
                    mul_b      = {32'd0, sqrt_r};
                    state_next = S_MUL3;
                end
            end
            S_MUL3:
            begin
                if (mul_done)
                begin
                    moe_next   = (mul_p[63:44] != 20'd0) ? {32{1'b1}} : mul_p[43:12];
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = (out_valid_reg && out_stall) || out_load;

    // Hold state, statistics, configuration and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mean_est_reg  <= wrv_pkg::MEAN_EST_RST;
            z_reg         <= wrv_pkg::Z_VALUE_RST;
            count_reg     <= '0;
            wsum_reg      <= '0;
            mean_reg      <= '0;
            sq_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wsum_reg      <= wsum_next;
            mean_reg      <= mean_next;
            sq_reg        <= sq_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    wrv_pkg::CFG_MEAN_EST: mean_est_reg <= cfg_data[0];
                    wrv_pkg::CFG_Z_VALUE:  z_reg        <= cfg_data;
                    default:               z_reg        <= z_reg;
                endcase
            end
        end
    end

    // Latch the request, working values and the output register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg   <= kind;
            value_reg  <= {sample_value, 16'd0};
            weight_reg <= sample_weight;
        end
        dneg_reg <= dneg_next;
        prod_reg <= prod_next;
        var_reg  <= var_next;
        sd_reg   <= sd_next;
        se_reg   <= se_next;
        moe_reg  <= moe_next;
        if (out_load)
        begin
            o_count_reg <= count_reg;
            o_wsum_reg  <= wsum_reg;
            o_mean_reg  <= mean_reg;
            o_var_reg   <= var_reg;
            o_sd_reg    <= sd_reg;
            o_se_reg    <= se_reg;
            o_moe_reg   <= moe_reg;
            o_sem_reg   <= !mean_est_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign unique_count  = o_count_reg;
    assign total_weight  = o_wsum_reg;
    assign mean_out      = o_mean_reg;
    assign variance_out  = o_var_reg;
    assign stdev_out     = o_sd_reg;
    assign std_error     = o_se_reg;
    assign margin_error  = o_moe_reg;
    assign sem_undefined = o_sem_reg;

    // A new result appears only from the final sequencer step
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside the final step");

    // No spread is reported for weight at most one
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (total_weight <= 48'd1) |->
            (variance_out == 64'd0) && (stdev_out == 32'd0) && (std_error == 32'd0))
        else $error("nonzero spread for weight at most one");

    // Standard error and margin are zero when the mean is not estimated
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sem_undefined |-> (std_error == 32'd0) && (margin_error == 32'd0))
        else $error("standard error reported while undefined");

    // A request is taken only when no unit reports done
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |-> !mul_done && !div_done && !sqrt_done)
        else $error("request taken while a unit finishes");

endmodule

// ----- hw/rtl/wrv_div.sv -----
// Restoring divider: 64-bit dividend by 48-bit divisor, one quotient bit per cycle.
module wrv_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [47:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic [47:0] rem_reg;
    logic [47:0] dsr_reg;
    logic [63:0] quo_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [48:0] shifted;
    logic [48:0] diff;

    // Bring down the next dividend bit and trial subtract
    assign shifted = {rem_reg, quo_reg[63]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dsr_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                if (shifted >= {1'b0, dsr_reg})
                begin
                    rem_reg <= diff[47:0];
                    quo_reg <= {quo_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_reg <= shifted[47:0];
                    quo_reg <= {quo_reg[62:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- hw/rtl/wrv_sqrt.sv -----
// Digit-by-digit integer square root of a 64-bit value, one root bit per cycle.
module wrv_sqrt
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] x_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [35:0] partial;
    logic [35:0] trial;
    logic [35:0] diff;

    // Append the next two radicand bits and test against 4*root+1
    assign partial = {rem_reg, x_reg[63:62]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign diff    = partial - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                x_reg    <= radicand;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            else if (busy_reg)
            begin
                x_reg <= {x_reg[61:0], 2'b00};
                if (partial >= trial)
                begin
                    rem_reg  <= diff[33:0];
                    root_reg <= {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= partial[33:0];
                    root_reg <= {root_reg[30:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ----- hw/rtl/wrv_mul.sv -----
// Shift-add multiplier: 64 by 64 bits to a 128-bit product, one multiplier bit per cycle.
module wrv_mul
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [63:0]  op_a,
    input  logic [63:0]  op_b,
    output logic         done,
    output logic [127:0] product
);

    logic [63:0] a_reg;
    logic [63:0] hi_reg;
    logic [63:0] lo_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [64:0] sum;

    // Add the multiplicand when the low multiplier bit is set
    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : 65'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                a_reg    <= op_a;
                hi_reg   <= '0;
                lo_reg   <= op_b;
            end
            else if (busy_reg)
            begin
                hi_reg  <= sum[64:1];
                lo_reg  <= {sum[0], lo_reg[63:1]};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule
